[rtl/bfns_pkg.sv]
// bfns_pkg: shared types and constants for the box face node set unit
// depends on nothing; imported by bfns_store and box_face_node_sets_unit
package bfns_pkg;

  localparam int COORD_W    = 32;
  localparam int TOL_W      = 20;
  localparam int NODE_IDX_W = 10;
  localparam int FACE_W     = 3;
  localparam int THR_W      = COORD_W + 2;

  // face codes in scan order
  localparam logic [FACE_W-1:0] FACE_XMIN = 3'd0;
  localparam logic [FACE_W-1:0] FACE_XMAX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_YMIN = 3'd2;
  localparam logic [FACE_W-1:0] FACE_YMAX = 3'd3;
  localparam logic [FACE_W-1:0] FACE_ZMIN = 3'd4;
  localparam logic [FACE_W-1:0] FACE_ZMAX = 3'd5;
  localparam logic [FACE_W-1:0] FACE_END  = 3'd6;

  // request codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  localparam logic signed [COORD_W-1:0] BOUND_MIN_RST = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] BOUND_MAX_RST = 32'sh8000_0000;

  localparam logic [TOL_W-1:0] TOL_RST = 20'd1;

  typedef struct packed {
    logic                       mode;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } in_t;

  typedef struct packed {
    logic [FACE_W-1:0]     face;
    logic [NODE_IDX_W-1:0] node_index;
    logic                  found;
    logic                  all_done;
    logic                  overflow;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FACE,
    ST_READ,
    ST_CMP
  } state_e;

endpackage

[rtl/box_face_node_sets_unit.sv]
// box_face_node_sets_unit: top level, point loading, bound tracking and face scan
// depends on bfns_pkg and bfns_store
//
// Collects a set of 3D points and reports, one per fetch, every (face, node)
// pair lying on a face of the set's bounding box, faces in the order x-min,
// x-max, y-min, y-max, z-min, z-max and nodes in load order, then a done
// marker on every further fetch. A transfer is taken when start is high and
// busy is low. A load (mode 0) leaves busy low, so loads stream at one per
// cycle while no fetch is under way; it produces no result. A load after any
// fetch begins a new set. Loads beyond MAX_POINTS are dropped and set the
// overflow flag. A fetch (mode 1) keeps busy high while a small sequencer
// walks the point memory: ST_FACE sets up the face threshold, each node
// examined passes through ST_READ (registered memory read) and ST_CMP (the
// shared compare against the threshold), and each face that runs out passes
// ST_READ and ST_FACE again. The scan is paced by the single read port of
// the point memory and the one comparator. The result shows on res_o with
// res_valid_o high for exactly one cycle, in the cycle busy falls; there is
// no back-pressure, the receiver must take it.
// The tolerance register may only be written while the block is idle.
// No clearing pass is needed: the memory is only read below the fill count.
module box_face_node_sets_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bfns_pkg::in_t                in_i,
  input  logic                         cfg_we_i,
  input  logic [bfns_pkg::TOL_W-1:0]   cfg_wdata_i,
  output logic                         res_valid_o,
  output bfns_pkg::out_t               res_o
);
  import bfns_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

  state_e state_q, state_d;

  logic [TOL_W-1:0]           tol_q;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              pos_q, pos_d;
  logic [FACE_W-1:0]          face_q, face_d;
  logic                       draining_q, draining_d;
  logic                       dropped_q, dropped_d;
  logic signed [COORD_W-1:0]  bounds_q [6];
  logic signed [COORD_W-1:0]  bounds_d [6];
  logic signed [THR_W-1:0]    thr_q, thr_d;
  logic                       res_valid_q, res_valid_d;
  out_t                       res_q, res_d;

  // memory interface
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr;
  point_t         mem_wdata, mem_rdata;

  // shared compare unit
  logic signed [COORD_W-1:0]  cmp_coord;
  logic signed [THR_W-1:0]    cmp_coord_ext;
  logic signed [THR_W-1:0]    bound_ext;
  logic signed [THR_W-1:0]    tol_ext;
  logic                       hit;

  logic signed [COORD_W-1:0]  load_c [3];

  assign load_c[0] = in_i.coord_x;
  assign load_c[1] = in_i.coord_y;
  assign load_c[2] = in_i.coord_z;

  assign mem_wdata = '{x: in_i.coord_x, y: in_i.coord_y, z: in_i.coord_z};

  bfns_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (pos_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // axis picked by the face under scan
  always_comb begin
    case (face_q[2:1])
      2'd0:    cmp_coord = mem_rdata.x;
      2'd1:    cmp_coord = mem_rdata.y;
      default: cmp_coord = mem_rdata.z;
    endcase
  end

  assign cmp_coord_ext = {{2{cmp_coord[COORD_W-1]}}, cmp_coord};
  // min faces: coordinate below min + tolerance; max faces: above max - tolerance
  assign hit = face_q[0] ? (cmp_coord_ext > thr_q) : (cmp_coord_ext < thr_q);

  // threshold for the current face, registered once per face entry
  assign bound_ext = (face_q < FACE_END)
                     ? {{2{bounds_q[face_q][COORD_W-1]}}, bounds_q[face_q]}
                     : '0;
  assign tol_ext   = {{(THR_W-TOL_W){1'b0}}, tol_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    face_d      = face_q;
    draining_d  = draining_q;
    dropped_d   = dropped_q;
    bounds_d    = bounds_q;
    thr_d       = thr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = count_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (in_i.mode == MODE_LOAD) begin
            // first load after a fetch opens a fresh set
            if (draining_q) begin
              count_d    = '0;
              pos_d      = '0;
              face_d     = FACE_XMIN;
              draining_d = 1'b0;
              dropped_d  = 1'b0;
              for (int a = 0; a < 3; a++) begin
                bounds_d[2*a]   = BOUND_MIN_RST;
                bounds_d[2*a+1] = BOUND_MAX_RST;
              end
            end
            if (count_d >= CAP) begin
              dropped_d = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_d[AW-1:0];
              for (int a = 0; a < 3; a++) begin
                if (load_c[a] < bounds_d[2*a])   bounds_d[2*a]   = load_c[a];
                if (load_c[a] > bounds_d[2*a+1]) bounds_d[2*a+1] = load_c[a];
              end
              count_d = count_d + 1'b1;
            end
          end else begin
            draining_d = 1'b1;
            state_d    = ST_FACE;
          end
        end
      end

      ST_FACE: begin
        if (face_q >= FACE_END) begin
          // every face exhausted: done marker
          res_d       = '{face: FACE_XMIN, node_index: '0, found: 1'b0,
                          all_done: 1'b1, overflow: dropped_q};
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          thr_d   = face_q[0] ? (bound_ext - tol_ext) : (bound_ext + tol_ext);
          state_d = ST_READ;
        end
      end

      ST_READ: begin
        if (pos_q < count_q) begin
          mem_re  = 1'b1;
          state_d = ST_CMP;
        end else begin
          face_d  = face_q + 1'b1;
          pos_d   = '0;
          state_d = ST_FACE;
        end
      end

      ST_CMP: begin
        pos_d = pos_q + 1'b1;
        if (hit) begin
          res_d       = '{face: face_q, node_index: NODE_IDX_W'(pos_q), found: 1'b1,
                          all_done: 1'b0, overflow: dropped_q};
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tol_q       <= TOL_RST;
      count_q     <= '0;
      pos_q       <= '0;
      face_q      <= FACE_XMIN;
      draining_q  <= 1'b0;
      dropped_q   <= 1'b0;
      res_valid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        bounds_q[2*a]   <= BOUND_MIN_RST;
        bounds_q[2*a+1] <= BOUND_MAX_RST;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      face_q      <= face_d;
      draining_q  <= draining_d;
      dropped_q   <= dropped_d;
      res_valid_q <= res_valid_d;
      bounds_q    <= bounds_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // result only appears once the sequencer has returned to idle
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while sequencer busy");

  // a result is either a pair or the done marker, never both
  a_res_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.found != res_o.all_done))
    else $error("result neither pair nor done marker");

  // a pair always names a real face
  a_pair_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.found) |-> (res_o.face < FACE_END))
    else $error("pair with face code out of range");

  // an accepted fetch always occupies the sequencer
  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.mode == MODE_FETCH) |=> busy)
    else $error("fetch accepted without starting scan");

  // fill count never passes capacity and scan never passes the fill count
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CAP) && (pos_q <= count_q))
    else $error("fill count or scan position out of range");

endmodule

[rtl/bfns_store.sv]
// bfns_store: point memory, one write port and one registered read port
// depends on bfns_pkg for the point type
module bfns_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  bfns_pkg::point_t  wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output bfns_pkg::point_t  rdata_o
);
  import bfns_pkg::*;

  point_t mem [DEPTH];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
